FILE: rtl/nbc_pkg.sv
package nbc_pkg;

	localparam int RoundCountDefault = 16;
	localparam int RoundCountMax     = 16;
	localparam int WordWidth         = 32;

	// config register indexes
	localparam logic [7:0] RegKeyWord0 = 8'd0;
	localparam logic [7:0] RegKeyWord1 = 8'd1;
	localparam logic [7:0] RegKeyWord2 = 8'd2;
	localparam logic [7:0] RegKeyWord3 = 8'd3;

	typedef logic [WordWidth-1:0] word_t;
	typedef logic [3:0][WordWidth-1:0] block_t;

	// one pipeline slot handed from cell to cell
	typedef struct packed {
		logic   vld;
		logic   dec;
		block_t a;
	} stage_t;

	// round constants, last entry repeats for any index past the table
	function automatic word_t rc_at(input int idx);
		logic [7:0] c;
		case (idx)
			0:       c = 8'h80;
			1:       c = 8'h1B;
			2:       c = 8'h36;
			3:       c = 8'h6C;
			4:       c = 8'hD8;
			5:       c = 8'hAB;
			6:       c = 8'h4D;
			7:       c = 8'h9A;
			8:       c = 8'h2F;
			9:       c = 8'h5E;
			10:      c = 8'hBC;
			11:      c = 8'h63;
			12:      c = 8'hC6;
			13:      c = 8'h97;
			14:      c = 8'h35;
			15:      c = 8'h6A;
			default: c = 8'hD4;
		endcase
		return {24'd0, c};
	endfunction

	function automatic word_t rotl(input word_t v, input int n);
		return (v << n) | (v >> (WordWidth - n));
	endfunction

	// linear mixing step with key addition
	function automatic block_t theta(input block_t k, input block_t a_in);
		block_t a;
		word_t  t;
		a = a_in;
		t = a[0] ^ a[2];
		t = t ^ rotl(t, 8) ^ rotl(t, 24);
		a[1] = a[1] ^ t;
		a[3] = a[3] ^ t;
		a[0] = a[0] ^ k[0];
		a[1] = a[1] ^ k[1];
		a[2] = a[2] ^ k[2];
		a[3] = a[3] ^ k[3];
		t = a[1] ^ a[3];
		t = t ^ rotl(t, 8) ^ rotl(t, 24);
		a[0] = a[0] ^ t;
		a[2] = a[2] ^ t;
		return a;
	endfunction

	// nonlinear step, bitsliced s-box over the four words
	function automatic block_t gamma_step(input block_t a_in);
		block_t a;
		word_t  t;
		a = a_in;
		a[1] = a[1] ^ (~a[3] & ~a[2]);
		a[0] = a[0] ^ (a[2] & a[1]);
		t    = a[3];
		a[3] = a[0];
		a[0] = t;
		a[2] = a[2] ^ a[0] ^ a[1] ^ a[3];
		a[1] = a[1] ^ (~a[3] & ~a[2]);
		a[0] = a[0] ^ (a[2] & a[1]);
		return a;
	endfunction

endpackage

FILE: rtl/nbc_round_cell.sv
module nbc_round_cell
	import nbc_pkg::*;
#(
	parameter int ROUND_COUNT = RoundCountDefault,
	parameter int CELL_IDX    = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  block_t key,
	input  block_t wkey,
	input  stage_t prev,
	output stage_t next
);

	localparam word_t EncConst = rc_at(CELL_IDX);
	localparam word_t DecConst = rc_at(ROUND_COUNT - CELL_IDX);

	block_t k;
	block_t a;
	stage_t next_q;

	// one full round, constants placed by direction
	always_comb begin
		k = prev.dec ? wkey : key;
		a = prev.a;
		a[0] = a[0] ^ (prev.dec ? '0 : EncConst);
		a = theta(k, a);
		a[0] = a[0] ^ (prev.dec ? DecConst : '0);
		a[1] = rotl(a[1], 1);
		a[2] = rotl(a[2], 5);
		a[3] = rotl(a[3], 2);
		a = gamma_step(a);
		a[1] = rotl(a[1], 31);
		a[2] = rotl(a[2], 27);
		a[3] = rotl(a[3], 30);
	end

	// slot valid and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
		end else if (en) begin
			next_q.vld <= prev.vld;
			next_q.dec <= prev.dec;
			next_q.a   <= a;
		end
	end

	assign next = next_q;

endmodule

FILE: rtl/nbc_final.sv
module nbc_final
	import nbc_pkg::*;
#(
	parameter int ROUND_COUNT = RoundCountDefault
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  block_t key,
	input  block_t wkey,
	input  stage_t prev,
	output stage_t result
);

	localparam word_t EncConst = rc_at(ROUND_COUNT);
	localparam word_t DecConst = rc_at(0);

	block_t a;
	stage_t result_q;

	// closing constant and theta, order set by direction
	always_comb begin
		a = prev.a;
		if (prev.dec) begin
			a = theta(wkey, a);
			a[0] = a[0] ^ DecConst;
		end else begin
			a[0] = a[0] ^ EncConst;
			a = theta(key, a);
		end
	end

	// output valid and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= '0;
		end else if (en) begin
			result_q.vld <= prev.vld;
			result_q.dec <= prev.dec;
			result_q.a   <= a;
		end
	end

	assign result = result_q;

endmodule

FILE: rtl/noekeon_block_cipher_core.sv
// Noekeon 128-bit block cipher, direct-key mode. Each item on s_axis is one
// block (tdata words 0..3, tuser 0 encrypt / 1 decrypt); m_axis returns the
// transformed block. The rounds are a chain of ROUND_COUNT round cells plus an
// input register and a closing stage, so the core takes one item per cycle
// unless m_axis_tready is low with a result waiting, which holds the whole
// chain. The key sits in config registers 0..3 (reset 0) and must only change
// with the chain empty; the decrypt working key is registered from the key.
module noekeon_block_cipher_core
	import nbc_pkg::*;
#(
	parameter int ROUND_COUNT = RoundCountDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // in_word0, in_word1, in_word2, in_word3
	input  logic         s_axis_tuser,  // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // out_word0, out_word1, out_word2, out_word3
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	block_t key_q;
	block_t wkey_q;
	logic   en;
	stage_t chain [ROUND_COUNT+1];
	stage_t in_q;
	stage_t result;

	// key registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegKeyWord0: key_q[0] <= cfg_data;
				RegKeyWord1: key_q[1] <= cfg_data;
				RegKeyWord2: key_q[2] <= cfg_data;
				RegKeyWord3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// decrypt working key: theta of the key under a zero key
	always_ff @(posedge clk) begin
		wkey_q <= theta('0, key_q);
	end

	// whole chain moves when the output slot is free or being taken
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q <= '0;
		end else if (en) begin
			in_q.vld <= s_axis_tvalid;
			in_q.dec <= s_axis_tuser;
			in_q.a   <= s_axis_tdata;
		end
	end

	assign chain[0] = in_q;

	// round cells
	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
		nbc_round_cell #(
			.ROUND_COUNT(ROUND_COUNT),
			.CELL_IDX   (i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.key   (key_q),
			.wkey  (wkey_q),
			.prev  (chain[i]),
			.next  (chain[i+1])
		);
	end

	// closing stage, doubles as output register
	nbc_final #(
		.ROUND_COUNT(ROUND_COUNT)
	) u_final (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.key   (key_q),
		.wkey  (wkey_q),
		.prev  (chain[ROUND_COUNT]),
		.result(result)
	);

	assign m_axis_tvalid = result.vld;
	assign m_axis_tdata  = result.a;

endmodule

FILE: verif/nbc_block_checker.sv
`timescale 1ns / 100ps

module nbc_block_checker
	import nbc_pkg::*;
#(
	parameter int ROUNDS = RoundCountDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // in_word0, in_word1, in_word2, in_word3
	input  logic         s_axis_tuser,  // req_type
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [127:0] m_axis_tdata,  // out_word0, out_word1, out_word2, out_word3
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	// round constant schedule, the last entry also covers any later index
	localparam logic [7:0] RoundConst [17] = '{
		8'h80, 8'h1B, 8'h36, 8'h6C, 8'hD8, 8'hAB, 8'h4D, 8'h9A,
		8'h2F, 8'h5E, 8'hBC, 8'h63, 8'hC6, 8'h97, 8'h35, 8'h6A, 8'hD4
	};

	block_t key_copy;
	block_t expected_blocks [$];
	int     shown;

	function automatic word_t round_const(input int idx);
		return {24'd0, RoundConst[(idx > 16) ? 16 : idx]};
	endfunction

	function automatic word_t rol32(input word_t v, input int n);
		logic [63:0] d;
		d = {v, v} << n;
		return d[63:32];
	endfunction

	// diffusion layer: mix halves, add key, mix the other halves
	function automatic block_t mix_words(input block_t k, input block_t a);
		block_t r;
		word_t  t;
		r = a;
		t = r[0] ^ r[2];
		t = t ^ rol32(t, 8) ^ rol32(t, 24);
		r[1] ^= t;
		r[3] ^= t;
		for (int w = 0; w < 4; w++)
			r[w] ^= k[w];
		t = r[1] ^ r[3];
		t = t ^ rol32(t, 8) ^ rol32(t, 24);
		r[0] ^= t;
		r[2] ^= t;
		return r;
	endfunction

	// bitsliced 4-bit s-box across the words
	function automatic block_t sbox_slices(input block_t a);
		block_t r;
		word_t  t;
		r = a;
		r[1] ^= ~r[3] & ~r[2];
		r[0] ^= r[2] & r[1];
		t = r[3];
		r[3] = r[0];
		r[0] = t;
		r[2] ^= r[0] ^ r[1] ^ r[3];
		r[1] ^= ~r[3] & ~r[2];
		r[0] ^= r[2] & r[1];
		return r;
	endfunction

	function automatic block_t cipher_round(input block_t k, input block_t a,
			input word_t pre_c, input word_t post_c);
		block_t r;
		r = a;
		r[0] ^= pre_c;
		r = mix_words(k, r);
		r[0] ^= post_c;
		r[1] = rol32(r[1], 1);
		r[2] = rol32(r[2], 5);
		r[3] = rol32(r[3], 2);
		r = sbox_slices(r);
		r[1] = rol32(r[1], 31);
		r[2] = rol32(r[2], 27);
		r[3] = rol32(r[3], 30);
		return r;
	endfunction

	// full transform of one block in either direction
	function automatic block_t transform_block(input logic dec, input block_t a,
			input block_t k);
		block_t r;
		block_t wk;
		r = a;
		if (!dec) begin
			for (int i = 0; i < ROUNDS; i++)
				r = cipher_round(k, r, round_const(i), '0);
			r[0] ^= round_const(ROUNDS);
			r = mix_words(k, r);
		end else begin
			wk = mix_words('0, k);
			for (int i = ROUNDS; i > 0; i--)
				r = cipher_round(wk, r, '0, round_const(i));
			r = mix_words(wk, r);
			r[0] ^= round_const(0);
		end
		return r;
	endfunction

	// track the key, queue expected blocks, compare each result item
	always @(posedge clk or negedge arst_n) begin : watch
		block_t want;
		int     bad;
		logic   took_in;
		logic   took_out;
		if (!arst_n) begin
			key_copy   <= '0;
			pending    <= 0;
			fail_count <= 0;
			shown      = 0;
			expected_blocks.delete();
		end else begin
			bad      = 0;
			took_in  = s_axis_tvalid && s_axis_tready;
			took_out = m_axis_tvalid && m_axis_tready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegKeyWord0: key_copy[0] <= cfg_data;
					RegKeyWord1: key_copy[1] <= cfg_data;
					RegKeyWord2: key_copy[2] <= cfg_data;
					RegKeyWord3: key_copy[3] <= cfg_data;
					default: ;
				endcase
			end
			if (took_in)
				expected_blocks.push_back(transform_block(s_axis_tuser, s_axis_tdata, key_copy));
			if (took_out) begin
				if (expected_blocks.size() == 0) begin
					bad++;
					if (shown < 10)
						$display("%0t: result item with none pending, got %h", $realtime,
							m_axis_tdata);
					shown++;
				end else begin
					want = expected_blocks.pop_front();
					for (int w = 0; w < 4; w++) begin
						if (m_axis_tdata[w*32 +: 32] !== want[w]) begin
							bad++;
							if (shown < 10)
								$display("%0t: out_word%0d expected %h, got %h", $realtime, w,
									want[w], m_axis_tdata[w*32 +: 32]);
							shown++;
						end
					end
				end
			end
			fail_count <= fail_count + bad;
			pending    <= pending + int'(took_in) - int'(took_out);
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import nbc_pkg::*;

	localparam int         CycleLimit   = 300000;
	localparam int         Latency      = RoundCountDefault + 2;
	localparam int         RandomPhases = 8;
	localparam int         PhaseItems   = 240;
	localparam int         SqueezeLen   = 300;
	localparam logic [7:0] RegBeyondKey = 8'd4;
	localparam logic [7:0] RegIndexTop  = 8'hFF;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata  = '0;
	logic         s_axis_tuser  = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         cfg_valid     = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_index     = '0;
	logic [31:0]  cfg_data      = '0;

	int   fail_count;
	int   pending;
	int   cycle_count  = 0;
	logic tx_steady    = 1'b0;
	logic rx_steady    = 1'b0;
	logic squeeze_req  = 1'b0;
	logic squeeze_done = 1'b0;

	noekeon_block_cipher_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	nbc_block_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off while the input keeps coming
	initial begin : rx_side
		int held;
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_done) begin
				m_axis_tready <= 1'b0;
				held = 0;
				while (held < SqueezeLen) begin
					@(posedge clk);
					held++;
				end
				m_axis_tready <= 1'b1;
				squeeze_done  <= 1'b1;
			end else if (rx_steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 7);
			end
		end
	end

	// offer one block item and hold it until taken
	task automatic send_block(input logic dec, input block_t blk);
		while (!tx_steady && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= blk;
		s_axis_tuser  <= dec;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering and wait until every expected block is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// load all key words, optionally a write to an unused index, then settle
	task automatic load_key(input block_t key, input logic stray, input logic [7:0] stray_idx);
		write_reg(RegKeyWord0, key[0]);
		write_reg(RegKeyWord1, key[1]);
		write_reg(RegKeyWord2, key[2]);
		write_reg(RegKeyWord3, key[3]);
		if (stray)
			write_reg(stray_idx, $urandom);
		cfg_valid <= 1'b0;
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		block_t blk;
		block_t key;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key: zero, all ones, alternating bits, one full word at a time
		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       blk = '0;
				1:       blk = '1;
				2:       blk = {4{32'h5555_5555}};
				3:       blk = {4{32'hAAAA_AAAA}};
				default: begin
					blk = '0;
					blk[p-4] = '1;
				end
			endcase
			send_block(1'b0, blk);
			send_block(1'b1, blk);
		end

		// all-ones key, stray writes to unused indexes must change nothing
		drain();
		load_key('1, 1'b1, RegBeyondKey);
		write_reg(RegIndexTop, $urandom);
		cfg_valid <= 1'b0;
		repeat (4) @(posedge clk);
		send_block(1'b0, '0);
		send_block(1'b1, '0);
		send_block(1'b0, '1);
		send_block(1'b1, '1);

		// random phases, each with a fresh key
		for (int ph = 0; ph < RandomPhases; ph++) begin
			drain();
			tx_steady <= (ph == 2);
			rx_steady <= (ph == 2);
			if (ph == 5)
				squeeze_req <= 1'b1;
			for (int w = 0; w < 4; w++) begin
				case ($urandom_range(9))
					0:       key[w] = '0;
					1:       key[w] = '1;
					default: key[w] = $urandom;
				endcase
			end
			if (ph == RandomPhases - 1)
				key = '0;
			load_key(key, ($urandom_range(3) == 0), 8'($urandom_range(255, 4)));
			for (int n = 0; n < PhaseItems; n++)
				send_block(1'($urandom_range(1)), {$urandom, $urandom, $urandom, $urandom});
		end

		drain();
		repeat (2 * Latency) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: noekeon_block_cipher_core.f
rtl/nbc_pkg.sv
rtl/nbc_round_cell.sv
rtl/nbc_final.sv
rtl/noekeon_block_cipher_core.sv
verif/nbc_block_checker.sv
verif/tb_top.sv
